// ===== rtl/core/npm_pkg.sv =====
// Shared types, constants and helpers for the nodata-aware pixel merge core.
// Has no dependencies; imported by nodata_pixel_merge_top.
`default_nettype none

package npm_pkg;

    localparam int NCH       = 4;   // channel lanes carried per pixel
    localparam int CH_W      = 8;
    localparam int SUM_W     = 10;  // sum of four distances, up to 4*255
    localparam int WT_W      = 9;   // pixel weight, 1..256
    localparam int DEN_W     = 10;  // weight sum, 2..512
    localparam int PROD_W    = 16;  // channel times weight, up to 255*256
    localparam int NUM_W     = 17;  // sum of two products
    localparam int MUL3_W    = 21;  // distance sum times the reciprocal of three
    localparam int DIV_STAGES = 4;
    localparam int QB_PER_STAGE = CH_W / DIV_STAGES;

    // Reciprocal of three, scaled by 2**RECIP3_SH. Exact for sums up to 3*255.
    localparam logic [10:0] RECIP3    = 11'd683;
    localparam int          RECIP3_SH = 11;

    // Pipeline stage positions in the valid chain.
    localparam int ST_IN   = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_WT   = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_ADD  = 4;
    localparam int ST_DIV0 = 5;
    localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
    localparam int NSTG    = ST_OUT + 1;

    // Configuration register indexes.
    localparam logic [1:0] REG_NODATA   = 2'd0;
    localparam logic [1:0] REG_MODE     = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // Merge modes; the unused fourth code behaves as average.
    localparam logic [1:0] MODE_AVERAGE  = 2'd0;
    localparam logic [1:0] MODE_KEEP     = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;

    // Supported channel counts.
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR  = 3'd4;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [NCH-1:0] pix_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        chan_t            q;
    } div_t;

    // One restoring division step that decides quotient bit k.
    function automatic div_t div_step(div_t x, logic [DEN_W-1:0] d, logic [2:0] k);
        logic [NUM_W-1:0] trial;
        div_t             y;
        trial = NUM_W'(d) << k;
        y     = x;
        if (x.rem >= trial)
        begin
            y.rem  = x.rem - trial;
            y.q[k] = 1'b1;
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nodata_pixel_merge_top.sv =====
// Nodata-aware merge of two co-located pixels: average, keep-first or
// distance-weighted blend. Depends on npm_pkg.
//
//   channel   signals                                  direction  handshake
//   in        first_ch*, second_ch*, in_last           input      in_valid / in_ready
//   out       merged_ch*, bad_channels, out_last       output     out_valid / out_ready
//   cfg       cfg_index, cfg_data                      input      cfg_we, no wait
//
// Ten register stages; one transaction can enter every cycle while an output
// stall has not backed up to in_ready. The weighted quotient
// is resolved two bits per stage over four stages.
// Each stage holds its item until the next stage is free, so a stall at the
// output fills the bubbles first and then backs up to in_ready.
// Reset clears the valid bits and sets nodata 0, mode average, one channel.
`default_nettype none

module nodata_pixel_merge_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire npm_pkg::chan_t       first_ch0,
    input  wire npm_pkg::chan_t       first_ch1,
    input  wire npm_pkg::chan_t       first_ch2,
    input  wire npm_pkg::chan_t       first_ch3,
    input  wire npm_pkg::chan_t       second_ch0,
    input  wire npm_pkg::chan_t       second_ch1,
    input  wire npm_pkg::chan_t       second_ch2,
    input  wire npm_pkg::chan_t       second_ch3,
    input  wire logic                 in_last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output npm_pkg::chan_t            merged_ch0,
    output npm_pkg::chan_t            merged_ch1,
    output npm_pkg::chan_t            merged_ch2,
    output npm_pkg::chan_t            merged_ch3,
    output logic                      bad_channels,
    output logic                      out_last
);
    import npm_pkg::*;

    // Configuration registers.
    chan_t      nodata_reg;
    logic [1:0] mode_reg;
    logic [2:0] count_reg;

    // Valid chain and per-stage advance.
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] adv;

    // Input stage.
    pix_t in_a_reg, in_b_reg;
    logic in_last_reg;

    // Distance sum stage.
    pix_t             s1_a_reg, s1_b_reg, s1_rs_reg;
    logic [SUM_W-1:0] s1_sa_reg, s1_sb_reg;
    logic             s1_bad_reg, s1_last_reg;
    pix_t             s1_rs_next;
    logic [SUM_W-1:0] s1_sa_next, s1_sb_next;
    logic             s1_bad_next;

    // Weight stage.
    pix_t            s2_a_reg, s2_b_reg, s2_rs_reg;
    logic [WT_W-1:0] s2_wa_reg, s2_wb_reg;
    logic            s2_bad_reg, s2_last_reg;

    // Product stage.
    logic [PROD_W-1:0] s3_pa_reg [NCH];
    logic [PROD_W-1:0] s3_pb_reg [NCH];
    logic [DEN_W-1:0]  s3_d_reg;
    pix_t              s3_rs_reg;
    logic              s3_bad_reg, s3_last_reg;

    // Numerator stage.
    logic [NUM_W-1:0] s4_num_reg [NCH];
    logic [DEN_W-1:0] s4_d_reg;
    pix_t             s4_rs_reg;
    logic             s4_bad_reg, s4_last_reg;

    // Divider stages.
    div_t [NCH-1:0]   dv_reg  [DIV_STAGES];
    div_t [NCH-1:0]   dv_next [DIV_STAGES];
    logic [DEN_W-1:0] dv_d_reg [DIV_STAGES];
    pix_t             dv_rs_reg [DIV_STAGES];
    logic             dv_bad_reg [DIV_STAGES];
    logic             dv_last_reg [DIV_STAGES];

    // Output stage.
    pix_t merged_reg, merged_next;
    logic bad_reg, last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodata_reg <= '0;
            mode_reg   <= MODE_AVERAGE;
            count_reg  <= CNT_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODATA:   nodata_reg <= cfg_data;
                REG_MODE:     mode_reg   <= cfg_data[1:0];
                REG_CHANNELS: count_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // A stage may load when it is empty or its item moves on this cycle.
    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[ST_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[ST_IN])
            begin
                v_reg[ST_IN] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
        begin
            in_a_reg    <= {first_ch3, first_ch2, first_ch1, first_ch0};
            in_b_reg    <= {second_ch3, second_ch2, second_ch1, second_ch0};
            in_last_reg <= in_last;
        end
    end

    // Nodata flags, distance sums and the average/keep result.
    always_comb
    begin
        logic             a_nd, b_nd, use_ch;
        logic [CH_W:0]    pair_sum;
        chan_t            da, db;
        a_nd        = 1'b1;
        b_nd        = 1'b1;
        da          = '0;
        db          = '0;
        s1_sa_next  = '0;
        s1_sb_next  = '0;
        s1_bad_next = !(count_reg == CNT_ONE || count_reg == CNT_THREE
                        || count_reg == CNT_FOUR);
        for (int i = 0; i < NCH; i++)
        begin
            use_ch = 3'(i) < count_reg;
            if (use_ch)
            begin
                if (in_a_reg[i] != nodata_reg)
                begin
                    a_nd = 1'b0;
                end
                if (in_b_reg[i] != nodata_reg)
                begin
                    b_nd = 1'b0;
                end
                da = (in_a_reg[i] >= nodata_reg) ? in_a_reg[i] - nodata_reg
                                                 : nodata_reg - in_a_reg[i];
                db = (in_b_reg[i] >= nodata_reg) ? in_b_reg[i] - nodata_reg
                                                 : nodata_reg - in_b_reg[i];
                s1_sa_next = s1_sa_next + SUM_W'(da);
                s1_sb_next = s1_sb_next + SUM_W'(db);
            end
        end
        for (int i = 0; i < NCH; i++)
        begin
            pair_sum = {1'b0, in_a_reg[i]} + {1'b0, in_b_reg[i]};
            if (a_nd)
            begin
                s1_rs_next[i] = in_b_reg[i];
            end
            else if (mode_reg == MODE_KEEP || b_nd)
            begin
                s1_rs_next[i] = in_a_reg[i];
            end
            else
            begin
                s1_rs_next[i] = pair_sum[CH_W:1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_SUM])
        begin
            s1_a_reg    <= in_a_reg;
            s1_b_reg    <= in_b_reg;
            s1_rs_reg   <= s1_rs_next;
            s1_sa_reg   <= s1_sa_next;
            s1_sb_reg   <= s1_sb_next;
            s1_bad_reg  <= s1_bad_next;
            s1_last_reg <= in_last_reg;
        end
    end

    // Weight is one plus the distance sum divided by the channel count; unsupported counts divide by three.
    function automatic logic [WT_W-1:0] weight(logic [SUM_W-1:0] s, logic [2:0] n);
        logic [MUL3_W-1:0] m;
        logic [WT_W-1:0]   q;
        m = MUL3_W'(s) * MUL3_W'(RECIP3);
        case (n)
            CNT_ONE:  q = WT_W'(s);
            CNT_FOUR: q = WT_W'(s >> 2);
            default:  q = WT_W'(m >> RECIP3_SH);
        endcase
        return q + WT_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[ST_WT])
        begin
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_rs_reg   <= s1_rs_reg;
            s2_wa_reg   <= weight(s1_sa_reg, count_reg);
            s2_wb_reg   <= weight(s1_sb_reg, count_reg);
            s2_bad_reg  <= s1_bad_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_MUL])
        begin
            for (int i = 0; i < NCH; i++)
            begin
                s3_pa_reg[i] <= PROD_W'(s2_a_reg[i]) * PROD_W'(s2_wa_reg);
                s3_pb_reg[i] <= PROD_W'(s2_b_reg[i]) * PROD_W'(s2_wb_reg);
            end
            s3_d_reg    <= DEN_W'(s2_wa_reg) + DEN_W'(s2_wb_reg);
            s3_rs_reg   <= s2_rs_reg;
            s3_bad_reg  <= s2_bad_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_ADD])
        begin
            for (int i = 0; i < NCH; i++)
            begin
                s4_num_reg[i] <= NUM_W'(s3_pa_reg[i]) + NUM_W'(s3_pb_reg[i]);
            end
            s4_d_reg    <= s3_d_reg;
            s4_rs_reg   <= s3_rs_reg;
            s4_bad_reg  <= s3_bad_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // The weighted mean never exceeds 255, so eight quotient bits suffice.
    always_comb
    begin
        div_t x;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                if (j == 0)
                begin
                    x.rem = s4_num_reg[i];
                    x.q   = '0;
                end
                else
                begin
                    x = dv_reg[j-1][i];
                end
                for (int b = 0; b < QB_PER_STAGE; b++)
                begin
                    x = div_step(x, (j == 0) ? s4_d_reg : dv_d_reg[j-1],
                                 3'(CH_W - 1 - j * QB_PER_STAGE - b));
                end
                dv_next[j][i] = x;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (adv[ST_DIV0 + j])
            begin
                dv_reg[j] <= dv_next[j];
                if (j == 0)
                begin
                    dv_d_reg[j]    <= s4_d_reg;
                    dv_rs_reg[j]   <= s4_rs_reg;
                    dv_bad_reg[j]  <= s4_bad_reg;
                    dv_last_reg[j] <= s4_last_reg;
                end
                else
                begin
                    dv_d_reg[j]    <= dv_d_reg[j-1];
                    dv_rs_reg[j]   <= dv_rs_reg[j-1];
                    dv_bad_reg[j]  <= dv_bad_reg[j-1];
                    dv_last_reg[j] <= dv_last_reg[j-1];
                end
            end
        end
    end

    // Final select; unused channels and unsupported counts read as zero.
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            if (dv_bad_reg[DIV_STAGES-1] || !(3'(i) < count_reg))
            begin
                merged_next[i] = '0;
            end
            else if (mode_reg == MODE_WEIGHTED)
            begin
                merged_next[i] = dv_reg[DIV_STAGES-1][i].q;
            end
            else
            begin
                merged_next[i] = dv_rs_reg[DIV_STAGES-1][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            merged_reg <= merged_next;
            bad_reg    <= dv_bad_reg[DIV_STAGES-1];
            last_reg   <= dv_last_reg[DIV_STAGES-1];
        end
    end

    assign out_valid    = v_reg[ST_OUT];
    assign merged_ch0   = merged_reg[0];
    assign merged_ch1   = merged_reg[1];
    assign merged_ch2   = merged_reg[2];
    assign merged_ch3   = merged_reg[3];
    assign bad_channels = bad_reg;
    assign out_last     = last_reg;

endmodule

`default_nettype wire
